// ===== sv/dpf_pkg.sv =====
package dpf_pkg;

  // Default number of stored packets
  localparam int unsigned DPF_DEPTH = 64;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned ENTRY_W = 2 * ID_W + STAMP_W;

  // Reset value of the capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ID_W-1:0]    src_id;
    logic [ID_W-1:0]    dst_id;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] range_start;
    logic [STAMP_W-1:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               packet_valid;
    logic [ID_W-1:0]    out_src;
    logic [ID_W-1:0]    out_dst;
    logic [STAMP_W-1:0] out_stamp;
    logic [CNT_W-1:0]   match_count;
  } out_item_t;

  // Stored entry: source, destination, timestamp from msb down
  typedef struct packed {
    logic [ID_W-1:0]    src;
    logic [ID_W-1:0]    dst;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

// ===== sv/dpf_if.sv =====
// Request channel
interface dpf_in_if;
  logic               valid;
  logic               ready;
  dpf_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface dpf_out_if;
  logic               valid;
  logic               ready;
  dpf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Capacity register write channel
interface dpf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dpf_pkg::CAP_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/dpf_ram.sv =====
module dpf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dedup_packet_fifo_with_range_count_unit.sv =====
// Packet FIFO with duplicate filter and range count.
// Channels: in_ch carries one request item (add, forward or count), out_ch
// returns exactly one result item per request, cfg_ch writes the capacity
// register (always ready; write only while the block is idle).
// Entries live in one DEPTH x 64 synchronous RAM used as a ring buffer.
// Steps: a request is taken only while idle; add and count then read every
//   stored entry, one RAM read per entry (none when the buffer is empty),
//   while forward and unknown codes go straight to the final step.
// The result is registered at the end of the final step, entered in the
// cycle after the compare of the last stored entry, and sits in an output
// register; a new request is taken while it waits. If the receiver
// stalls with that register full, the block finishes the next request and
// holds in its final step until the register frees.
// Reset (rst_n low, synchronous) empties the buffer, sets capacity to 64
// and drops any pending result. RAM contents are not cleared; only slots
// inside the occupied window are ever read.
module dedup_packet_fifo_with_range_count_unit #(
  parameter int unsigned DEPTH = dpf_pkg::DPF_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  dpf_in_if.sink    in_ch,
  dpf_out_if.source out_ch,
  dpf_cfg_if.sink   cfg_ch
);

  import dpf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;

  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Control and ring state
  logic [1:0]       state_r, state_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [OW-1:0]    issued_r, issued_nxt;
  logic             dup_r, dup_nxt;
  logic [OW-1:0]    cnt_r, cnt_nxt;
  in_item_t         req_r, req_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // RAM port signals
  logic             ram_we;
  logic [PW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [PW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  entry_t           rd_entry;
  entry_t           key;
  logic [CW-1:0]    eff_cap;
  logic             out_free;
  logic             hit_dup;
  logic             hit_cnt;

  dpf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign rd_entry = entry_t'(ram_rdata);
  assign key      = '{src: req_r.src_id, dst: req_r.dst_id, stamp: req_r.stamp};
  assign out_free = !out_valid_r || out_ch.ready;

  // Capacity clamped to 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_r) > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  // Per-entry compares on the word just read
  assign hit_dup = (rd_entry == key);
  assign hit_cnt = (rd_entry.dst == req_r.dst_id) &&
                   (rd_entry.stamp >= req_r.range_start) &&
                   (rd_entry.stamp <= req_r.range_end);

  // Sequencer: accept, scan the ring one entry a cycle for add and count, then commit
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    cap_nxt       = cap_r;
    rptr_nxt      = rptr_r;
    issued_nxt    = issued_r;
    dup_nxt       = dup_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_wdata     = ENTRY_W'(key);
    ram_re        = 1'b0;
    ram_raddr     = rptr_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      cap_nxt = cfg_ch.data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt    = in_ch.data;
          dup_nxt    = 1'b0;
          cnt_nxt    = '0;
          ram_raddr  = head_r;
          rptr_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + PW'(1);
          issued_nxt = OW'(1);
          state_nxt  = ST_FIN;
          if (in_ch.data.operation == OP_FWD) begin
            ram_re = (occ_r != '0);
          end else if ((in_ch.data.operation == OP_ADD ||
                        in_ch.data.operation == OP_COUNT) && occ_r != '0) begin
            ram_re    = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit_dup) begin
          dup_nxt = 1'b1;
        end
        if (hit_cnt) begin
          cnt_nxt = cnt_r + OW'(1);
        end
        if (issued_r < occ_r) begin
          ram_re     = 1'b1;
          rptr_nxt   = (rptr_r == LAST_SLOT) ? '0 : rptr_r + PW'(1);
          issued_nxt = issued_r + OW'(1);
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
          case (req_r.operation)
            OP_ADD: begin
              if (!dup_r) begin
                out_data_nxt.accepted = 1'b1;
                // Append at the tail; evict the oldest when at capacity
                ram_we   = 1'b1;
                tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + PW'(1);
                if (CW'(occ_r) >= eff_cap && occ_r != '0) begin
                  head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + PW'(1);
                end else begin
                  occ_nxt = occ_r + OW'(1);
                end
              end
            end
            OP_FWD: begin
              if (occ_r != '0) begin
                out_data_nxt.packet_valid = 1'b1;
                out_data_nxt.out_src      = rd_entry.src;
                out_data_nxt.out_dst      = rd_entry.dst;
                out_data_nxt.out_stamp    = rd_entry.stamp;
                head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + PW'(1);
                occ_nxt  = occ_r - OW'(1);
              end
            end
            OP_COUNT: begin
              out_data_nxt.match_count = CNT_W'(cnt_r);
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    rptr_r     <= rptr_nxt;
    issued_r   <= issued_nxt;
    dup_r      <= dup_nxt;
    cnt_r      <= cnt_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
